[design/hvt_pkg.sv]
`default_nettype none
package hvt_pkg;

  // Coordinate and coefficient formats
  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int IO_W       = 32;
  localparam int CF_W       = 32;
  localparam int CFG_W      = 2 * CF_W;
  localparam int NUM_REGS   = 8;
  localparam int IDX_W      = $clog2(NUM_REGS);

  // Dot product widths: three products plus the translation term, all exact
  localparam int PROD_W = CF_W + COORD_BITS;
  localparam int TERM_W = CF_W + FRAC_BITS;
  localparam int SUM_W  = ((PROD_W > TERM_W) ? PROD_W : TERM_W) + 2;
  localparam int DOT_W  = SUM_W - FRAC_BITS;
  localparam int MAG_W  = DOT_W;
  localparam int NUM_W  = MAG_W + FRAC_BITS;
  localparam int Q_W    = COORD_BITS;

  // Pipeline layout
  localparam int DOT_STAGES = 3;
  localparam int DIV_STAGES = Q_W;
  localparam int ST_PREP    = DOT_STAGES;
  localparam int ST_DIV0    = DOT_STAGES + 1;
  localparam int NS         = DOT_STAGES + 1 + DIV_STAGES + 1;
  localparam int ST_OUT     = NS - 1;
  localparam int LANES      = 3;

  typedef logic signed [IO_W-1:0]       io_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [CF_W-1:0]       coef_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [SUM_W-1:0]      sum_t;
  typedef logic signed [DOT_W-1:0]      dot_t;
  typedef logic [MAG_W-1:0]             mag_t;
  typedef logic [NUM_W-1:0]             num_t;
  typedef logic [Q_W-1:0]               quo_t;
  typedef logic [CFG_W-1:0]             cfg_word_t;

  typedef enum logic [IDX_W-1:0] {
    REG_ROW0_LO, REG_ROW0_HI, REG_ROW1_LO, REG_ROW1_HI,
    REG_ROW2_LO, REG_ROW2_HI, REG_ROW3_LO, REG_ROW3_HI
  } cfg_reg_t;

  localparam cfg_word_t ONE_Q = cfg_word_t'(1) << FRAC_BITS;

  // Per-stage load enables from the pipeline control
  typedef struct packed {
    logic [NS-1:0] en;
  } pipe_ctl_t;

  // One coordinate in flight through the divider
  typedef struct packed {
    logic neg;
    logic sat;
    mag_t r;
    quo_t low;
    quo_t q;
  } div_lane_t;

endpackage
`default_nettype wire

[design/hvt_in_if.sv]
`default_nettype none
interface hvt_in_if;
  logic          valid;
  logic          ready;
  hvt_pkg::io_t  in_x;
  hvt_pkg::io_t  in_y;
  hvt_pkg::io_t  in_z;
  modport source (output valid, output in_x, output in_y, output in_z, input ready);
  modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface
`default_nettype wire

[design/hvt_out_if.sv]
`default_nettype none
interface hvt_out_if;
  logic          valid;
  logic          ready;
  hvt_pkg::io_t  out_x;
  hvt_pkg::io_t  out_y;
  hvt_pkg::io_t  out_z;
  logic          w_zero;
  logic          overflow;
  modport source (output valid, output out_x, output out_y, output out_z,
                  output w_zero, output overflow, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z,
                  input w_zero, input overflow, output ready);
endinterface
`default_nettype wire

[design/hvt_ctrl.sv]
`default_nettype none
module hvt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output hvt_pkg::pipe_ctl_t     ctl
);

  logic [hvt_pkg::NS-1:0] v_r;
  logic [hvt_pkg::NS-1:0] v_nxt;
  logic [hvt_pkg::NS-1:0] en;

  // A stage loads when it is empty or its contents move on
  assign en[hvt_pkg::NS-1] = !v_r[hvt_pkg::NS-1] || out_ready;
  for (genvar i = 0; i < hvt_pkg::NS - 1; i++) begin : g_en
    assign en[i] = !v_r[i] || en[i+1];
  end

  // Valid bits follow the data
  always_comb begin
    v_nxt = v_r;
    if (en[0]) v_nxt[0] = in_valid;
    for (int i = 1; i < hvt_pkg::NS; i++) begin
      if (en[i]) v_nxt[i] = v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign ctl.en    = en;
  assign in_ready  = en[0];
  assign out_valid = v_r[hvt_pkg::NS-1];

endmodule
`default_nettype wire

[design/hvt_dot.sv]
`default_nettype none
module hvt_dot (
  input  wire logic                              clk,
  input  wire logic [hvt_pkg::DOT_STAGES-1:0]    en,
  input  wire hvt_pkg::cfg_word_t                row_lo,
  input  wire hvt_pkg::cfg_word_t                row_hi,
  input  wire hvt_pkg::coord_t                   x,
  input  wire hvt_pkg::coord_t                   y,
  input  wire hvt_pkg::coord_t                   z,
  output hvt_pkg::dot_t                          dot
);

  localparam hvt_pkg::sum_t HALF_LSB = hvt_pkg::sum_t'(1) << (hvt_pkg::FRAC_BITS - 1);

  hvt_pkg::coef_t c0, c1, c2, c3;
  hvt_pkg::prod_t p0_r, p1_r, p2_r;
  hvt_pkg::coef_t c3_r;
  hvt_pkg::sum_t  s01_r, s2_r, sum;
  hvt_pkg::dot_t  dot_r;

  assign c0 = hvt_pkg::coef_t'(row_lo[hvt_pkg::CFG_W-1:hvt_pkg::CF_W]);
  assign c1 = hvt_pkg::coef_t'(row_lo[hvt_pkg::CF_W-1:0]);
  assign c2 = hvt_pkg::coef_t'(row_hi[hvt_pkg::CFG_W-1:hvt_pkg::CF_W]);
  assign c3 = hvt_pkg::coef_t'(row_hi[hvt_pkg::CF_W-1:0]);

  // Stage 1: exact products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      p0_r <= hvt_pkg::prod_t'(c0) * hvt_pkg::prod_t'(x);
      p1_r <= hvt_pkg::prod_t'(c1) * hvt_pkg::prod_t'(y);
      p2_r <= hvt_pkg::prod_t'(c2) * hvt_pkg::prod_t'(z);
      c3_r <= c3;
    end
  end

  // Stage 2: pairwise sums, translation term and rounding half
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s01_r <= hvt_pkg::sum_t'(p0_r) + hvt_pkg::sum_t'(p1_r);
      s2_r  <= hvt_pkg::sum_t'(p2_r) + (hvt_pkg::sum_t'(c3_r) <<< hvt_pkg::FRAC_BITS)
               + HALF_LSB;
    end
  end

  // Stage 3: final sum, floor to FRAC_BITS fraction bits
  assign sum = s01_r + s2_r;
  always_ff @(posedge clk) begin
    if (en[2]) begin
      dot_r <= hvt_pkg::dot_t'(sum[hvt_pkg::SUM_W-1:hvt_pkg::FRAC_BITS]);
    end
  end

  assign dot = dot_r;

endmodule
`default_nettype wire

[design/hvt_div.sv]
`default_nettype none
module hvt_div (
  input  wire logic                              clk,
  input  wire logic [hvt_pkg::DIV_STAGES-1:0]    en,
  input  wire hvt_pkg::div_lane_t                lane_in [hvt_pkg::LANES],
  input  wire hvt_pkg::mag_t                     ad_in,
  input  wire logic                              wz_in,
  output hvt_pkg::div_lane_t                     lane_out [hvt_pkg::LANES],
  output hvt_pkg::mag_t                          ad_out,
  output logic                                   wz_out
);

  hvt_pkg::div_lane_t lane_r [hvt_pkg::DIV_STAGES][hvt_pkg::LANES];
  hvt_pkg::mag_t      ad_r   [hvt_pkg::DIV_STAGES];
  logic               wz_r   [hvt_pkg::DIV_STAGES];

  // One restoring step per stage, one quotient bit per lane
  for (genvar s = 0; s < hvt_pkg::DIV_STAGES; s++) begin : g_st
    hvt_pkg::div_lane_t prv [hvt_pkg::LANES];
    hvt_pkg::div_lane_t nxt [hvt_pkg::LANES];
    hvt_pkg::mag_t      prv_ad;
    logic               prv_wz;

    if (s == 0) begin : g_first
      assign prv    = lane_in;
      assign prv_ad = ad_in;
      assign prv_wz = wz_in;
    end else begin : g_rest
      assign prv    = lane_r[s-1];
      assign prv_ad = ad_r[s-1];
      assign prv_wz = wz_r[s-1];
    end

    always_comb begin
      logic [hvt_pkg::MAG_W:0] rem2;
      logic                    ge;
      for (int l = 0; l < hvt_pkg::LANES; l++) begin
        rem2       = {prv[l].r, prv[l].low[hvt_pkg::Q_W-1]};
        ge         = rem2 >= {1'b0, prv_ad};
        nxt[l]     = prv[l];
        nxt[l].r   = ge ? hvt_pkg::mag_t'(rem2 - {1'b0, prv_ad})
                        : rem2[hvt_pkg::MAG_W-1:0];
        nxt[l].low = prv[l].low << 1;
        nxt[l].q   = {prv[l].q[hvt_pkg::Q_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        lane_r[s] <= nxt;
        ad_r[s]   <= prv_ad;
        wz_r[s]   <= prv_wz;
      end
    end
  end

  assign lane_out = lane_r[hvt_pkg::DIV_STAGES-1];
  assign ad_out   = ad_r[hvt_pkg::DIV_STAGES-1];
  assign wz_out   = wz_r[hvt_pkg::DIV_STAGES-1];

endmodule
`default_nettype wire

[design/homogeneous_vertex_transform_top.sv]
// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    in_x, in_y, in_z (Q16.16)
// out_ch    out  valid/ready    out_x, out_y, out_z, w_zero, overflow
// cfg       in   cfg_we         cfg_idx (0..7), cfg_data (two coefficients)
//
// One vertex per cycle while the output is not stalled.
// Pipeline: 3 multiply/accumulate stages, 1 divide setup stage, 32 stages of
// restoring division (one quotient bit each), 1 saturate/output stage.
// Reset clears the valid bits and loads the identity matrix.
// A stalled output holds; empty stages still fill, so input is taken
// until every stage holds a vertex.
`default_nettype none
module homogeneous_vertex_transform_top (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  hvt_in_if.sink                         in_ch,
  hvt_out_if.source                      out_ch,
  input  wire logic                      cfg_we,
  input  wire logic [hvt_pkg::IDX_W-1:0] cfg_idx,
  input  wire hvt_pkg::cfg_word_t        cfg_data
);

  localparam hvt_pkg::quo_t HALF_Q = hvt_pkg::quo_t'(1) << (hvt_pkg::Q_W - 1);

  hvt_pkg::pipe_ctl_t ctl;
  hvt_pkg::cfg_word_t cfg_r [hvt_pkg::NUM_REGS];
  hvt_pkg::coord_t    cx, cy, cz;
  hvt_pkg::dot_t      dot [4];

  // Matrix registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < hvt_pkg::NUM_REGS; i++) cfg_r[i] <= '0;
      cfg_r[hvt_pkg::REG_ROW0_LO] <= hvt_pkg::ONE_Q << hvt_pkg::CF_W;
      cfg_r[hvt_pkg::REG_ROW1_LO] <= hvt_pkg::ONE_Q;
      cfg_r[hvt_pkg::REG_ROW2_HI] <= hvt_pkg::ONE_Q << hvt_pkg::CF_W;
      cfg_r[hvt_pkg::REG_ROW3_HI] <= hvt_pkg::ONE_Q;
    end else if (cfg_we) begin
      cfg_r[cfg_idx] <= cfg_data;
    end
  end

  hvt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .ctl       (ctl)
  );

  assign cx = hvt_pkg::coord_t'(in_ch.in_x[hvt_pkg::COORD_BITS-1:0]);
  assign cy = hvt_pkg::coord_t'(in_ch.in_y[hvt_pkg::COORD_BITS-1:0]);
  assign cz = hvt_pkg::coord_t'(in_ch.in_z[hvt_pkg::COORD_BITS-1:0]);

  // Four row dot products in parallel
  for (genvar r = 0; r < 4; r++) begin : g_row
    hvt_dot u_dot (
      .clk    (clk),
      .en     (ctl.en[hvt_pkg::DOT_STAGES-1:0]),
      .row_lo (cfg_r[2*r]),
      .row_hi (cfg_r[2*r+1]),
      .x      (cx),
      .y      (cy),
      .z      (cz),
      .dot    (dot[r])
    );
  end

  // Divide setup: signs, magnitudes, early saturation test
  hvt_pkg::div_lane_t prep_nxt [hvt_pkg::LANES];
  hvt_pkg::div_lane_t prep_r   [hvt_pkg::LANES];
  hvt_pkg::mag_t      ad_nxt, ad_r;
  logic               wz_r;

  assign ad_nxt = dot[3][hvt_pkg::DOT_W-1] ? hvt_pkg::mag_t'(-dot[3])
                                             : hvt_pkg::mag_t'(dot[3]);

  always_comb begin
    hvt_pkg::mag_t an;
    hvt_pkg::num_t n;
    hvt_pkg::num_t hi;
    for (int l = 0; l < hvt_pkg::LANES; l++) begin
      an = dot[l][hvt_pkg::DOT_W-1] ? hvt_pkg::mag_t'(-dot[l]) : hvt_pkg::mag_t'(dot[l]);
      n  = {an, {hvt_pkg::FRAC_BITS{1'b0}}};
      hi = n >> hvt_pkg::Q_W;
      prep_nxt[l].neg = dot[l][hvt_pkg::DOT_W-1] ^ dot[3][hvt_pkg::DOT_W-1];
      prep_nxt[l].sat = hi >= hvt_pkg::num_t'(ad_nxt);
      prep_nxt[l].r   = hi[hvt_pkg::MAG_W-1:0];
      prep_nxt[l].low = n[hvt_pkg::Q_W-1:0];
      prep_nxt[l].q   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[hvt_pkg::ST_PREP]) begin
      prep_r <= prep_nxt;
      ad_r   <= ad_nxt;
      wz_r   <= (dot[3] == '0);
    end
  end

  hvt_pkg::div_lane_t dq [hvt_pkg::LANES];
  hvt_pkg::mag_t      ad_end;
  logic               wz_end;

  hvt_div u_div (
    .clk      (clk),
    .en       (ctl.en[hvt_pkg::ST_OUT-1:hvt_pkg::ST_DIV0]),
    .lane_in  (prep_r),
    .ad_in    (ad_r),
    .wz_in    (wz_r),
    .lane_out (dq),
    .ad_out   (ad_end),
    .wz_out   (wz_end)
  );

  // Saturate, apply sign, output register
  hvt_pkg::io_t res_nxt [hvt_pkg::LANES];
  logic         ovf_nxt;
  hvt_pkg::io_t res_r   [hvt_pkg::LANES];
  logic         ovf_r, wz_out_r;

  always_comb begin
    hvt_pkg::quo_t limit;
    hvt_pkg::quo_t mag;
    logic          ov;
    ovf_nxt = 1'b0;
    for (int l = 0; l < hvt_pkg::LANES; l++) begin
      limit = dq[l].neg ? HALF_Q : HALF_Q - hvt_pkg::quo_t'(1);
      ov    = dq[l].sat || (dq[l].q > limit);
      mag   = ov ? limit : dq[l].q;
      if (dq[l].neg) mag = -mag;
      res_nxt[l] = wz_end ? '0 : hvt_pkg::io_t'(hvt_pkg::coord_t'(mag));
      ovf_nxt    = ovf_nxt || (ov && !wz_end);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[hvt_pkg::ST_OUT]) begin
      res_r    <= res_nxt;
      ovf_r    <= ovf_nxt && (ad_end != '0);
      wz_out_r <= wz_end;
    end
  end

  assign out_ch.out_x    = res_r[0];
  assign out_ch.out_y    = res_r[1];
  assign out_ch.out_z    = res_r[2];
  assign out_ch.w_zero   = wz_out_r;
  assign out_ch.overflow = ovf_r;

endmodule
`default_nettype wire

[design/hvt_checker.sv]
`default_nettype none
module hvt_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_ready,
  input wire logic         out_valid,
  input wire logic         out_ready,
  input wire hvt_pkg::io_t out_x,
  input wire hvt_pkg::io_t out_y,
  input wire hvt_pkg::io_t out_z,
  input wire logic         w_zero,
  input wire logic         overflow
);

  localparam hvt_pkg::io_t MAXV = hvt_pkg::io_t'((64'sd1 <<< (hvt_pkg::COORD_BITS - 1)) - 1);
  localparam hvt_pkg::io_t MINV = hvt_pkg::io_t'(-(64'sd1 <<< (hvt_pkg::COORD_BITS - 1)));

  // Output valid held until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // Zero w gives zero coordinates and no overflow
  a_wzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && w_zero |-> out_x == '0 && out_y == '0 && out_z == '0 && !overflow)
    else $error("w_zero result not cleared");

  // Overflow means some coordinate sits at a bound
  a_ovf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && overflow |-> out_x == MAXV || out_x == MINV || out_y == MAXV ||
      out_y == MINV || out_z == MAXV || out_z == MINV)
    else $error("overflow without saturated coordinate");

  // Input stalls only when the pipe is full and the output is blocked
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with room in pipeline");

  // Nothing valid right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid after reset");

endmodule

bind homogeneous_vertex_transform_top hvt_checker u_hvt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_x     (out_ch.out_x),
  .out_y     (out_ch.out_y),
  .out_z     (out_ch.out_z),
  .w_zero    (out_ch.w_zero),
  .overflow  (out_ch.overflow)
);
`default_nettype wire

[dv/tb_top.sv]
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    hvt_pkg::io_t x;
    hvt_pkg::io_t y;
    hvt_pkg::io_t z;
    logic         w_zero;
    logic         overflow;
  } vertex_result_t;

  // Expected projected vertices plus a private copy of the matrix
  class vertex_scoreboard;
    hvt_pkg::cfg_word_t matrix_regs[hvt_pkg::NUM_REGS];
    vertex_result_t     pending[$];
    int                 mismatches;
    int                 checked;

    function void init_identity();
      matrix_regs[hvt_pkg::REG_ROW0_LO] = hvt_pkg::ONE_Q << hvt_pkg::CF_W;
      matrix_regs[hvt_pkg::REG_ROW0_HI] = '0;
      matrix_regs[hvt_pkg::REG_ROW1_LO] = hvt_pkg::ONE_Q;
      matrix_regs[hvt_pkg::REG_ROW1_HI] = '0;
      matrix_regs[hvt_pkg::REG_ROW2_LO] = '0;
      matrix_regs[hvt_pkg::REG_ROW2_HI] = hvt_pkg::ONE_Q << hvt_pkg::CF_W;
      matrix_regs[hvt_pkg::REG_ROW3_LO] = '0;
      matrix_regs[hvt_pkg::REG_ROW3_HI] = hvt_pkg::ONE_Q;
    endfunction

    // Exact dot product with (x, y, z, 1), rounded half up to FRAC_BITS
    function wide_t row_dot(int row, hvt_pkg::io_t x, hvt_pkg::io_t y, hvt_pkg::io_t z);
      hvt_pkg::coef_t c0, c1, c2, c3;
      wide_t s;
      c0 = matrix_regs[2*row][63:32];
      c1 = matrix_regs[2*row][31:0];
      c2 = matrix_regs[2*row+1][63:32];
      c3 = matrix_regs[2*row+1][31:0];
      s = wide_t'(c0) * wide_t'(x) + wide_t'(c1) * wide_t'(y) + wide_t'(c2) * wide_t'(z)
          + (wide_t'(c3) <<< hvt_pkg::FRAC_BITS);
      return (s + (wide_t'(1) <<< (hvt_pkg::FRAC_BITS - 1))) >>> hvt_pkg::FRAC_BITS;
    endfunction

    // Truncating divide c/w in Q16.16, clamped; integer part checked first
    function hvt_pkg::io_t divide_clamp(wide_t num, wide_t den, ref logic ovf);
      logic        neg;
      logic [127:0] an, ad, q, lim;
      neg = (num < 0) != (den < 0);
      an  = (num < 0) ? -num : num;
      ad  = (den < 0) ? -den : den;
      lim = neg ? (128'(1) << 31) : (128'(1) << 31) - 1;
      if (an / ad > (lim >> hvt_pkg::FRAC_BITS)) q = lim + 1;
      else q = (an << hvt_pkg::FRAC_BITS) / ad;
      if (q > lim) begin
        q = lim;
        ovf = 1'b1;
      end
      return neg ? hvt_pkg::io_t'(-q) : hvt_pkg::io_t'(q);
    endfunction

    function void note_vertex(hvt_pkg::io_t x, hvt_pkg::io_t y, hvt_pkg::io_t z);
      vertex_result_t r;
      wide_t tx, ty, tz, tw;
      logic ovf;
      tx = row_dot(0, x, y, z);
      ty = row_dot(1, x, y, z);
      tz = row_dot(2, x, y, z);
      tw = row_dot(3, x, y, z);
      ovf = 1'b0;
      if (tw == 0) begin
        r = '{x: '0, y: '0, z: '0, w_zero: 1'b1, overflow: 1'b0};
      end else begin
        r.x = divide_clamp(tx, tw, ovf);
        r.y = divide_clamp(ty, tw, ovf);
        r.z = divide_clamp(tz, tw, ovf);
        r.w_zero = 1'b0;
        r.overflow = ovf;
      end
      pending.push_back(r);
    endfunction

    function void check_vertex(vertex_result_t got);
      vertex_result_t exp_r;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected output transfer x=%h y=%h z=%h", got.x, got.y, got.z);
        return;
      end
      exp_r = pending.pop_front();
      if (got.x !== exp_r.x || got.y !== exp_r.y || got.z !== exp_r.z ||
          got.w_zero !== exp_r.w_zero || got.overflow !== exp_r.overflow) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: exp x=%h y=%h z=%h wz=%b ov=%b, got x=%h y=%h z=%h wz=%b ov=%b",
                   exp_r.x, exp_r.y, exp_r.z, exp_r.w_zero, exp_r.overflow,
                   got.x, got.y, got.z, got.w_zero, got.overflow);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [hvt_pkg::IDX_W-1:0] cfg_idx;
  hvt_pkg::cfg_word_t cfg_data;

  hvt_in_if  in_ch ();
  hvt_out_if out_ch ();

  homogeneous_vertex_transform_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  vertex_scoreboard sb = new();
  bit calm_send;
  bit calm_recv;
  int vertices_sent;
  int w_zero_seen;
  int overflow_seen;

  // Sink side: random stalls per transfer
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      gap = calm_recv ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Output monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_vertex('{x: out_ch.out_x, y: out_ch.out_y, z: out_ch.out_z,
                        w_zero: out_ch.w_zero, overflow: out_ch.overflow});
      w_zero_seen   += out_ch.w_zero;
      overflow_seen += out_ch.overflow;
    end
  end

  task automatic send_vertex(hvt_pkg::io_t x, hvt_pkg::io_t y, hvt_pkg::io_t z);
    int gap;
    gap = calm_send ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_x  <= x;
    in_ch.in_y  <= y;
    in_ch.in_z  <= z;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_vertex(x, y, z);
    vertices_sent++;
  endtask

  // Drop valid and let the pipeline empty before touching the matrix
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic load_matrix(hvt_pkg::cfg_word_t m[hvt_pkg::NUM_REGS]);
    drain();
    for (int i = 0; i < hvt_pkg::NUM_REGS; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= hvt_pkg::cfg_reg_t'(i);
      cfg_data <= m[i];
      sb.matrix_regs[i] = m[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic hvt_pkg::io_t rand_coord();
    case ($urandom_range(0, 3))
      0: return hvt_pkg::io_t'($urandom());
      1: return hvt_pkg::io_t'($urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 3)
                                                   : 32'h80000000 + $urandom_range(0, 3));
      default: return hvt_pkg::io_t'(int'($urandom_range(0, 400 << 16)) - (200 << 16));
    endcase
  endfunction

  function automatic hvt_pkg::cfg_word_t pack2(int a, int b);
    return {a[31:0], b[31:0]};
  endfunction

  function automatic int rand_coef();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 0;
      default: return int'($urandom_range(0, 8 << 16)) - (4 << 16);
    endcase
  endfunction

  // Main stimulus
  initial begin
    hvt_pkg::cfg_word_t m[hvt_pkg::NUM_REGS];
    hvt_pkg::io_t edge_vals[6];
    sb.init_identity();
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= '0;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.in_x <= '0;
    in_ch.in_y <= '0;
    in_ch.in_z <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: identity matrix from reset, coordinate extremes and bit patterns
    edge_vals = '{32'sh0, 32'sh7fffffff, 32'sh80000000, 32'sh55555555, 32'shaaaaaaaa, -32'sd1};
    foreach (edge_vals[i]) send_vertex(edge_vals[i], edge_vals[(i+1)%6], edge_vals[(i+2)%6]);

    // Directed: zero w row gives a flagged zero result
    m = '{pack2(1 << 16, 0), 0, pack2(0, 1 << 16), 0, 0, pack2(1 << 16, 0), 0, 0};
    load_matrix(m);
    send_vertex(32'sh12345, -32'sh10000, 32'sh7fffffff);
    send_vertex(0, 0, 0);

    // Directed: perspective w = -z, divide by small and exact -32768 boundary
    m = '{pack2(1 << 16, 0), 0, pack2(0, 1 << 16), 0, 0, pack2(1 << 16, 0),
          0, pack2(-(1 << 16), 0)};
    load_matrix(m);
    send_vertex(32'sh80000000, 32'sh7fffffff, -32'sh10000);
    send_vertex(32'sh80000000, 32'sh10000, 32'sh10000);
    send_vertex(32'sh40000, -32'sh40000, 32'sh1);
    send_vertex(32'sh40000, 32'sh30000, 32'sh20000);
    send_vertex(1, 2, 0);

    // Directed: extreme coefficients everywhere
    m = '{pack2(32'h7fffffff, 32'h80000000), pack2(32'h7fffffff, 32'h80000000),
          pack2(32'h80000000, 32'h7fffffff), pack2(32'h80000000, 32'h7fffffff),
          pack2(32'h7fffffff, 32'h7fffffff), pack2(32'h7fffffff, 32'h7fffffff),
          pack2(32'h80000000, 32'h80000000), pack2(32'h80000000, 32'h80000000)};
    load_matrix(m);
    foreach (edge_vals[i]) send_vertex(edge_vals[i], edge_vals[(i+3)%6], edge_vals[(i+4)%6]);

    // Random phases: mostly small affine and perspective matrices, some wild ones
    for (int phase = 0; phase < 16; phase++) begin
      int kind;
      kind = phase % 4;
      foreach (m[i]) m[i] = pack2(rand_coef(), rand_coef());
      if (kind == 0) begin
        m[hvt_pkg::REG_ROW3_LO] = 0;
        m[hvt_pkg::REG_ROW3_HI] = pack2(0, 1 << 16);
      end else if (kind == 1) begin
        m[hvt_pkg::REG_ROW3_LO] = 0;
        m[hvt_pkg::REG_ROW3_HI] = pack2(-(1 << 16), 0);
      end else if (kind == 2 && phase == 6) begin
        m[hvt_pkg::REG_ROW3_LO] = 0;
        m[hvt_pkg::REG_ROW3_HI] = 0;
      end else if (kind == 2) begin
        foreach (m[i]) m[i] = {$urandom(), $urandom()};
      end
      load_matrix(m);
      calm_send = (phase % 5 == 3);
      calm_recv = (phase % 7 == 2);
      for (int n = 0; n < 105; n++) begin
        if (phase == 9 && n == 50) begin
          // Hold off the sender until everything is back
          in_ch.valid <= 1'b0;
          @(posedge clk);
          while (sb.pending.size() != 0) @(posedge clk);
        end
        send_vertex(rand_coord(), rand_coord(), rand_coord());
      end
    end
    calm_send = 1'b0;
    calm_recv = 1'b0;

    drain();
    $display("Sent %0d vertices through 20 matrix settings, checked %0d results",
             vertices_sent, sb.checked);
    $display("Saw %0d zero-w and %0d saturated results, %0d mismatches",
             w_zero_seen, overflow_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("homogeneous_vertex_transform_top verification clean");
    else
      $display("homogeneous_vertex_transform_top verification failed");
    $finish;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("ERROR: timeout");
    $display("homogeneous_vertex_transform_top verification failed");
    $finish;
  end

endmodule
`default_nettype wire

[sim.f]
design/hvt_pkg.sv
design/hvt_in_if.sv
design/hvt_out_if.sv
design/hvt_ctrl.sv
design/hvt_dot.sv
design/hvt_div.sv
design/homogeneous_vertex_transform_top.sv
design/hvt_checker.sv
dv/tb_top.sv
